### rtl/cbm_pkg.sv
package cbm_pkg;

    localparam logic [1:0] OP_CPU_WR = 2'd0;
    localparam logic [1:0] OP_CPU_RD = 2'd1;
    localparam logic [1:0] OP_PPU_RD = 2'd2;
    localparam logic [1:0] OP_PPU_WR = 2'd3;

    localparam logic [2:0] SRC_PASS   = 3'd0;
    localparam logic [2:0] SRC_MAPPER = 3'd1;
    localparam logic [2:0] SRC_CIRAM  = 3'd2;
    localparam logic [2:0] SRC_CHR    = 3'd3;
    localparam logic [2:0] SRC_PRGROM = 3'd4;
    localparam logic [2:0] SRC_PRGRAM = 3'd5;
    localparam logic [2:0] SRC_DROP   = 3'd6;

    localparam logic [15:0] ADDR_PRG_MODE  = 16'h5100;
    localparam logic [15:0] ADDR_CHR_MODE  = 16'h5101;
    localparam logic [15:0] ADDR_EX_MODE   = 16'h5104;
    localparam logic [15:0] ADDR_NT_SEL    = 16'h5105;
    localparam logic [15:0] ADDR_FILL_CHAR = 16'h5106;
    localparam logic [15:0] ADDR_FILL_COL  = 16'h5107;
    localparam logic [15:0] ADDR_PRG_LO    = 16'h5113;
    localparam logic [15:0] ADDR_PRG_HI    = 16'h5117;
    localparam logic [15:0] ADDR_CHR_LO    = 16'h5120;
    localparam logic [15:0] ADDR_CHR_HI    = 16'h512B;
    localparam logic [15:0] ADDR_CHR_UP    = 16'h5130;
    localparam logic [15:0] ADDR_IRQ_TGT   = 16'h5203;
    localparam logic [15:0] ADDR_IRQ_STAT  = 16'h5204;
    localparam logic [15:0] ADDR_MULT_A    = 16'h5205;
    localparam logic [15:0] ADDR_MULT_B    = 16'h5206;
    localparam logic [15:0] ADDR_EXRAM     = 16'h5C00;
    localparam logic [15:0] ADDR_PRG_WIN   = 16'h6000;

    localparam logic [9:0] ATTR_OFFSET = 10'h3C0;

endpackage

### rtl/cbm_ram.sv
module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### rtl/cartridge_bank_mapper_with_exram_core.sv
// Bank mapper core with 1 KB extended RAM. One bus request (CPU or PPU) per
// cycle unless in_stall holds it; each accepted request's result moves from
// the stage 1 register to the output register. Stage 1 decodes the request,
// updates registers and issues the extended RAM access; stage 2 picks up the
// registered RAM read. The RAM has one write and one read port; a write lands
// at its accept edge, so a read accepted on the next cycle already sees the new
// byte. A result waiting under stall blocks the input only when the output
// register is full and not taken.
module cartridge_bank_mapper_with_exram_core #(
    parameter int EXRAM_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  open_bus_data,
    input  logic        blanking,
    input  logic        sprite_fetch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [2:0]  data_source,
    output logic [22:0] ext_address,
    output logic        irq_line,
    output logic        frame_seen
);
    import cbm_pkg::*;

    localparam int AW = $clog2(EXRAM_DEPTH);

    typedef struct packed {
        logic        use_ram;
        logic [7:0]  rd;
        logic [2:0]  src;
        logic [22:0] xa;
        logic        irq;
        logic        frame;
    } res_t;

    logic [1:0]  prg_mode_reg, chr_mode_reg, exram_mode_reg;
    logic [1:0]  nt_sel_reg [4];
    logic [7:0]  fill_char_reg, fill_color_reg;
    logic [7:0]  prg_page_reg [5];
    logic [9:0]  chr_page_reg [12];
    logic [9:0]  chr_upper_reg;
    logic [7:0]  mult_a_reg, mult_b_reg, irq_target_reg;
    logic        irq_enable_reg, irq_pending_reg, frame_active_reg;
    logic [7:0]  scanline_reg;
    logic [13:0] last_ppu_reg;
    logic [1:0]  repeat_reg;
    logic [15:0] product;

    logic        s1_valid_reg;
    res_t        s1_reg;

    logic        out_valid_reg;
    logic [7:0]  read_data_reg;
    logic [2:0]  data_source_reg;
    logic [22:0] ext_address_reg;
    logic        irq_line_reg, frame_seen_reg;

    logic        accept, s1_move;
    logic        ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_rdata;
    res_t        res_next;

    logic [7:0]  prg_v;
    logic [1:0]  slot;
    logic [13:0] pa;
    logic [9:0]  off;
    logic [1:0]  sel;
    logic [9:0]  cbank;
    logic [12:0] coff;
    logic [22:0] cxa;
    logic        nt_hit;
    logic [1:0]  rep_inc;
    logic [7:0]  scan_inc;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign accept   = in_valid && !in_stall;

    assign product = mult_a_reg * mult_b_reg;

    cbm_ram #(.WIDTH(8), .DEPTH(EXRAM_DEPTH)) u_exram (
        .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(write_data),
        .rd_en(ram_re), .rd_addr(ram_raddr), .rd_data(ram_rdata)
    );

    // PRG bank select
    always_comb
    begin
        slot = address[14:13];
        prg_v = 8'h00;
        if (!address[15])
        begin
            prg_v = prg_page_reg[0] & ((prg_mode_reg == 2'd0) ? 8'h7C : 8'h7E);
        end
        else
        begin
            unique case (prg_mode_reg)
                2'd0: prg_v = (prg_page_reg[4] & 8'h7C) | 8'h80 | {6'd0, slot};
                2'd1: prg_v = !slot[1] ? ((prg_page_reg[2] & 8'hFE) | {7'd0, slot[0]})
                                       : ((prg_page_reg[4] & 8'hFE) | 8'h80 | {7'd0, slot[0]});
                2'd2:
                begin
                    if (!slot[1])
                        prg_v = (prg_page_reg[2] & 8'hFE) | {7'd0, slot[0]};
                    else if (slot == 2'd2)
                        prg_v = prg_page_reg[3];
                    else
                        prg_v = prg_page_reg[4] | 8'h80;
                end
                default:
                begin
                    if (slot == 2'd3)
                        prg_v = prg_page_reg[4] | 8'h80;
                    else
                        prg_v = prg_page_reg[{1'b0, slot} + 3'd1];
                end
            endcase
        end
    end

    // CHR translate
    always_comb
    begin
        pa = address[13:0];
        coff = pa[12:0];
        unique case (chr_mode_reg)
            2'd0:
            begin
                cbank = sprite_fetch ? chr_page_reg[11] : chr_page_reg[7];
                cxa = {cbank, coff};
            end
            2'd1:
            begin
                cbank = sprite_fetch ? chr_page_reg[11]
                                     : (coff[12] ? chr_page_reg[7] : chr_page_reg[3]);
                cxa = {1'b0, cbank, coff[11:0]};
            end
            2'd2:
            begin
                cbank = sprite_fetch ? chr_page_reg[{2'b10, coff[11], 1'b1}]
                                     : chr_page_reg[{1'b0, coff[12:11], 1'b1}];
                cxa = {2'd0, cbank, coff[10:0]};
            end
            default:
            begin
                cbank = sprite_fetch ? chr_page_reg[{2'b10, coff[11:10]}]
                                     : chr_page_reg[{1'b0, coff[12:10]}];
                cxa = {3'd0, cbank, coff[9:0]};
            end
        endcase
    end

    assign off    = pa[9:0];
    assign sel    = nt_sel_reg[pa[11:10]];
    assign nt_hit = (pa[13:12] == 2'b10) && (pa == last_ppu_reg);
    assign rep_inc  = repeat_reg + 2'd1;
    assign scan_inc = scanline_reg + 8'd1;

    // decode
    always_comb
    begin
        res_next = '0;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_waddr = address[AW-1:0];
        ram_raddr = address[AW-1:0];
        if (!operation[1])
        begin
            if (address >= ADDR_PRG_WIN)
            begin
                if (operation == OP_CPU_WR && prg_v[7])
                    res_next.src = SRC_DROP;
                else
                begin
                    res_next.src = prg_v[7] ? SRC_PRGROM : SRC_PRGRAM;
                    res_next.xa = {3'd0, prg_v[6:0], address[12:0]};
                end
            end
            else if (address >= ADDR_EXRAM)
            begin
                if (operation == OP_CPU_WR)
                begin
                    if (exram_mode_reg == 2'd2 || (!exram_mode_reg[1] && blanking))
                    begin
                        ram_we = 1'b1;
                        res_next.src = SRC_MAPPER;
                    end
                    else
                        res_next.src = SRC_DROP;
                end
                else
                begin
                    res_next.src = SRC_MAPPER;
                    if (!exram_mode_reg[1])
                        res_next.rd = open_bus_data;
                    else
                    begin
                        ram_re = 1'b1;
                        res_next.use_ram = 1'b1;
                    end
                end
            end
            else if (operation == OP_CPU_WR)
            begin
                if ((address >= ADDR_PRG_LO && address <= ADDR_PRG_HI)
                    || (address >= ADDR_CHR_LO && address <= ADDR_CHR_HI)
                    || address == ADDR_PRG_MODE || address == ADDR_CHR_MODE
                    || address == ADDR_EX_MODE || address == ADDR_NT_SEL
                    || address == ADDR_FILL_CHAR || address == ADDR_FILL_COL
                    || address == ADDR_CHR_UP || address == ADDR_IRQ_TGT
                    || address == ADDR_IRQ_STAT || address == ADDR_MULT_A
                    || address == ADDR_MULT_B)
                    res_next.src = SRC_MAPPER;
            end
            else
            begin
                if (address == ADDR_IRQ_STAT)
                begin
                    res_next.src = SRC_MAPPER;
                    res_next.rd = {frame_active_reg, irq_pending_reg, 6'd0};
                end
                else if (address == ADDR_MULT_A)
                begin
                    res_next.src = SRC_MAPPER;
                    res_next.rd = product[7:0];
                end
                else if (address == ADDR_MULT_B)
                begin
                    res_next.src = SRC_MAPPER;
                    res_next.rd = product[15:8];
                end
            end
        end
        else
        begin
            ram_waddr = off[AW-1:0];
            ram_raddr = off[AW-1:0];
            if (!pa[13])
            begin
                if (operation == OP_PPU_RD)
                begin
                    res_next.src = SRC_CHR;
                    res_next.xa = cxa;
                end
                else
                    res_next.src = SRC_DROP;
            end
            else if (!sel[1])
            begin
                res_next.src = SRC_CIRAM;
                res_next.xa = {12'd0, sel[0], off};
            end
            else if (sel == 2'd2)
            begin
                res_next.src = SRC_MAPPER;
                if (operation == OP_PPU_RD)
                begin
                    ram_re = 1'b1;
                    res_next.use_ram = 1'b1;
                end
                else
                    ram_we = 1'b1;
            end
            else if (operation == OP_PPU_RD)
            begin
                res_next.src = SRC_MAPPER;
                res_next.rd = (off >= ATTR_OFFSET) ? fill_color_reg : fill_char_reg;
            end
            else
                res_next.src = SRC_DROP;
        end
        ram_we = ram_we && accept;
        ram_re = ram_re && accept;
    end

    // status after this request, as seen by its result
    logic irq_pend_next, frame_next;
    logic [7:0] scan_next;
    logic [1:0] rep_next;
    res_t       s1_next;
    always_comb
    begin
        irq_pend_next = irq_pending_reg;
        frame_next = frame_active_reg;
        scan_next = scanline_reg;
        rep_next = repeat_reg;
        if (operation == OP_CPU_RD && address == ADDR_IRQ_STAT)
            irq_pend_next = 1'b0;
        if (operation == OP_PPU_RD)
        begin
            if (nt_hit)
            begin
                rep_next = rep_inc;
                if (rep_inc == 2'd2)
                begin
                    rep_next = 2'd0;
                    if (!frame_active_reg)
                    begin
                        frame_next = 1'b1;
                        scan_next = 8'd0;
                    end
                    else
                    begin
                        scan_next = scan_inc;
                        if (scan_inc == irq_target_reg)
                            irq_pend_next = 1'b1;
                    end
                end
            end
            else
                rep_next = 2'd0;
        end
    end

    // a write to the status register takes its new enable bit at once
    always_comb
    begin
        s1_next = res_next;
        s1_next.irq = irq_pend_next && irq_enable_reg
            && !(operation == OP_CPU_WR && address == ADDR_IRQ_STAT)
            || irq_pend_next && (operation == OP_CPU_WR && address == ADDR_IRQ_STAT)
               && write_data[7];
        s1_next.frame = frame_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_mode_reg <= 2'd3;
            chr_mode_reg <= 2'd0;
            exram_mode_reg <= 2'd0;
            for (int i = 0; i < 4; i++) nt_sel_reg[i] <= 2'd0;
            fill_char_reg <= 8'd0;
            fill_color_reg <= 8'd0;
            for (int i = 0; i < 5; i++) prg_page_reg[i] <= (i == 4) ? 8'hFF : 8'h00;
            for (int i = 0; i < 12; i++) chr_page_reg[i] <= 10'd0;
            chr_upper_reg <= 10'd0;
            mult_a_reg <= 8'hFF;
            mult_b_reg <= 8'hFF;
            irq_target_reg <= 8'd0;
            irq_enable_reg <= 1'b0;
            irq_pending_reg <= 1'b0;
            frame_active_reg <= 1'b0;
            scanline_reg <= 8'd0;
            last_ppu_reg <= 14'd0;
            repeat_reg <= 2'd0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept || (s1_valid_reg && !s1_move);
            if (accept)
            begin
                irq_pending_reg <= irq_pend_next;
                frame_active_reg <= frame_next;
                scanline_reg <= scan_next;
                repeat_reg <= rep_next;
                if (operation == OP_PPU_RD)
                    last_ppu_reg <= pa;
                if (operation == OP_CPU_WR)
                begin
                    if (address >= ADDR_PRG_LO && address <= ADDR_PRG_HI)
                        prg_page_reg[3'(address - ADDR_PRG_LO)] <= write_data;
                    if (address >= ADDR_CHR_LO && address <= ADDR_CHR_HI)
                        chr_page_reg[4'(address - ADDR_CHR_LO)] <=
                            chr_upper_reg | {2'd0, write_data};
                    unique case (address)
                        ADDR_PRG_MODE:  prg_mode_reg <= write_data[1:0];
                        ADDR_CHR_MODE:  chr_mode_reg <= write_data[1:0];
                        ADDR_EX_MODE:   exram_mode_reg <= write_data[1:0];
                        ADDR_NT_SEL:
                        begin
                            nt_sel_reg[0] <= write_data[1:0];
                            nt_sel_reg[1] <= write_data[3:2];
                            nt_sel_reg[2] <= write_data[5:4];
                            nt_sel_reg[3] <= write_data[7:6];
                        end
                        ADDR_FILL_CHAR: fill_char_reg <= write_data;
                        ADDR_FILL_COL:  fill_color_reg <= {4{write_data[1:0]}};
                        ADDR_CHR_UP:    chr_upper_reg <= {write_data[1:0], 8'd0};
                        ADDR_IRQ_TGT:   irq_target_reg <= write_data;
                        ADDR_IRQ_STAT:  irq_enable_reg <= write_data[7];
                        ADDR_MULT_A:    mult_a_reg <= write_data;
                        ADDR_MULT_B:    mult_b_reg <= write_data;
                        default: ;
                    endcase
                end
            end
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload of stage 1 and of the output register
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        if (s1_move)
        begin
            read_data_reg <= s1_reg.use_ram ? ram_rdata : s1_reg.rd;
            data_source_reg <= s1_reg.src;
            ext_address_reg <= s1_reg.xa;
            irq_line_reg <= s1_reg.irq;
            frame_seen_reg <= s1_reg.frame;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign data_source = data_source_reg;
    assign ext_address = ext_address_reg;
    assign irq_line    = irq_line_reg;
    assign frame_seen  = frame_seen_reg;

    // stage 1 held while output register is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && out_stall |=> s1_valid_reg)
        else $error("stage 1 lost while output stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty pipe");
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> accept)
        else $error("exram write without request");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(data_source_reg))
        else $error("stalled result changed");
endmodule
